[sv/qrc_pkg.sv]
// ----------------------------------------------------------------------------
// qrc_pkg: shared definitions for the quadratic root count unit
// Register map offsets and reset values of the configuration registers.
// ----------------------------------------------------------------------------
package qrc_pkg;

  localparam int unsigned DegW = 4;
  localparam int unsigned ModW = 13;

  localparam logic [2:0] AddrDegree  = 3'd0;
  localparam logic [2:0] AddrModulus = 3'd4;

  localparam logic [DegW-1:0] DegreeReset  = 4'd8;
  localparam logic [ModW-1:0] ModulusReset = 13'd285;

  localparam logic [1:0] CountNone = 2'd0;
  localparam logic [1:0] CountOne  = 2'd1;
  localparam logic [1:0] CountTwo  = 2'd2;

endpackage

[sv/gf2m_quadratic_root_count_unit.sv]
// ----------------------------------------------------------------------------
// gf2m_quadratic_root_count_unit: root count of w^2 + L*w + M over GF(2^n)
// Pipelined inversion by repeated squaring, then a trace chain.
// ----------------------------------------------------------------------------
// One transaction is accepted in every cycle; busy_o is always low. Each
// result appears on root_count_o with root_count_valid_o high for one cycle,
// after passing the input register, the two chains of MAX_DEGREE squaring
// cells, and the quotient and output registers.
// The receiver cannot stall, so results must be taken when strobed.
// Configuration must be written only while no transaction is in flight;
// the block does not hold writes off, and items in the pipeline would see
// the new degree and modulus part way through.
module gf2m_quadratic_root_count_unit
  import qrc_pkg::*;
#(
  parameter int unsigned MAX_DEGREE = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [11:0] linear_coeff_i,
  input  logic [11:0] constant_coeff_i,
  output logic        root_count_valid_o,
  output logic [1:0]  root_count_o
);

  localparam int unsigned W  = MAX_DEGREE;
  localparam int unsigned NW = $clog2(MAX_DEGREE + 1) > DegW ? $clog2(MAX_DEGREE + 1) : DegW;

  logic [DegW-1:0] deg_q;
  logic [ModW-1:0] mod_q;
  logic [NW-1:0]   n;
  logic [W-1:0]    mask, modlow, lin, con, lsq;
  logic            wr;

  assign pready_o = 1'b1;
  assign busy_o   = 1'b0;
  assign wr       = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_q <= DegreeReset;
      mod_q <= ModulusReset;
    end else if (wr) begin
      if (paddr_i == AddrDegree)  deg_q <= pwdata_i[DegW-1:0];
      if (paddr_i == AddrModulus) mod_q <= pwdata_i[ModW-1:0];
    end
  end

  always_comb begin
    prdata_o = '0;
    if (paddr_i == AddrDegree)  prdata_o = 32'(deg_q);
    if (paddr_i == AddrModulus) prdata_o = 32'(mod_q);
  end

  // Effective degree is clamped to 1..MAX_DEGREE.
  always_comb begin
    if (deg_q == '0) begin
      n = NW'(1);
    end else if (NW'(deg_q) > NW'(MAX_DEGREE)) begin
      n = NW'(MAX_DEGREE);
    end else begin
      n = NW'(deg_q);
    end
  end

  always_comb begin
    for (int k = 0; k < W; k++) begin
      mask[k]   = (NW'(k) < n);
      modlow[k] = (k < ModW) ? (mask[k] & mod_q[k % ModW]) : 1'b0;
    end
    for (int k = 0; k < W; k++) begin
      lin[k] = mask[k] & ((k < 12) ? linear_coeff_i[k % 12] : 1'b0);
      con[k] = mask[k] & ((k < 12) ? constant_coeff_i[k % 12] : 1'b0);
    end
  end

  qrc_mul #(.W(W)) u_lsq (.a_i(lin), .b_i(lin), .mask_i(mask), .modlow_i(modlow),
                          .p_o(lsq));

  logic         s0_valid_q, s0_zero_q;
  logic [W-1:0] s0_con_q, s0_lsq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s0_valid_q <= 1'b0;
    else         s0_valid_q <= start_i;
  end

  always_ff @(posedge clk_i) begin
    s0_zero_q <= (lin == '0);
    s0_con_q  <= con;
    s0_lsq_q  <= lsq;
  end

  // Inversion chain: acc gathers L^2 raised to 2^1 .. 2^(n-1).
  logic         iv_valid [W+1];
  logic         iv_zero  [W+1];
  logic [W-1:0] iv_con   [W+1];
  logic [W-1:0] iv_x     [W+1];
  logic [W-1:0] iv_acc   [W+1];

  assign iv_valid[0] = s0_valid_q;
  assign iv_zero[0]  = s0_zero_q;
  assign iv_con[0]   = s0_con_q;
  assign iv_x[0]     = s0_lsq_q;
  assign iv_acc[0]   = W'(1);

  for (genvar g = 0; g < W; g++) begin : g_inv
    qrc_cell #(.W(W), .NW(NW), .IDX(g), .TRACE(1'b0)) u_cell (
      .clk_i, .rst_ni, .n_i(n), .mask_i(mask), .modlow_i(modlow),
      .valid_i(iv_valid[g]), .zero_i(iv_zero[g]), .con_i(iv_con[g]),
      .x_i(iv_x[g]), .acc_i(iv_acc[g]),
      .valid_o(iv_valid[g+1]), .zero_o(iv_zero[g+1]), .con_o(iv_con[g+1]),
      .x_o(iv_x[g+1]), .acc_o(iv_acc[g+1])
    );
  end

  logic [W-1:0] quot;
  logic         q_valid_q, q_zero_q;
  logic [W-1:0] q_c_q;

  qrc_mul #(.W(W)) u_quot (.a_i(iv_con[W]), .b_i(iv_acc[W]), .mask_i(mask),
                           .modlow_i(modlow), .p_o(quot));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) q_valid_q <= 1'b0;
    else         q_valid_q <= iv_valid[W];
  end

  always_ff @(posedge clk_i) begin
    q_zero_q <= iv_zero[W];
    q_c_q    <= quot;
  end

  // Trace chain: acc sums c^(2^i) for i below n.
  logic         tr_valid [W+1];
  logic         tr_zero  [W+1];
  logic [W-1:0] tr_con   [W+1];
  logic [W-1:0] tr_x     [W+1];
  logic [W-1:0] tr_acc   [W+1];

  assign tr_valid[0] = q_valid_q;
  assign tr_zero[0]  = q_zero_q;
  assign tr_con[0]   = '0;
  assign tr_x[0]     = q_c_q;
  assign tr_acc[0]   = '0;

  for (genvar g = 0; g < W; g++) begin : g_tr
    qrc_cell #(.W(W), .NW(NW), .IDX(g), .TRACE(1'b1)) u_cell (
      .clk_i, .rst_ni, .n_i(n), .mask_i(mask), .modlow_i(modlow),
      .valid_i(tr_valid[g]), .zero_i(tr_zero[g]), .con_i(tr_con[g]),
      .x_i(tr_x[g]), .acc_i(tr_acc[g]),
      .valid_o(tr_valid[g+1]), .zero_o(tr_zero[g+1]), .con_o(tr_con[g+1]),
      .x_o(tr_x[g+1]), .acc_o(tr_acc[g+1])
    );
  end

  logic       out_valid_q;
  logic [1:0] out_cnt_d, out_cnt_q;

  always_comb begin
    if (tr_zero[W])            out_cnt_d = CountOne;
    else if (tr_acc[W] == '0)  out_cnt_d = CountTwo;
    else                       out_cnt_d = CountNone;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= tr_valid[W];
  end

  always_ff @(posedge clk_i) begin
    out_cnt_q <= out_cnt_d;
  end

  assign root_count_valid_o = out_valid_q;
  assign root_count_o       = out_cnt_q;

endmodule

[sv/qrc_mul.sv]
// ----------------------------------------------------------------------------
// qrc_mul: polynomial-basis field multiplier
// Combinational MSB-first multiply with interleaved reduction by the modulus.
// ----------------------------------------------------------------------------
module qrc_mul #(
  parameter int unsigned W = 12
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] mask_i,
  input  logic [W-1:0] modlow_i,
  output logic [W-1:0] p_o
);

  logic [W-1:0] topsel;

  // One-hot select of bit n-1.
  assign topsel = mask_i ^ (mask_i >> 1);

  always_comb begin
    logic [W-1:0] p;
    logic         top;
    p = '0;
    for (int i = W - 1; i >= 0; i--) begin
      top = |(p & topsel);
      p   = ((p << 1) & mask_i) ^ (top ? modlow_i : '0) ^ (b_i[i] ? a_i : '0);
    end
    p_o = p;
  end

endmodule

[sv/qrc_cell.sv]
// ----------------------------------------------------------------------------
// qrc_cell: one cell of the squaring chain
// Squares the running power and folds it into the accumulator, by product
// in the inversion chain or by sum in the trace chain.
// ----------------------------------------------------------------------------
module qrc_cell
  import qrc_pkg::*;
#(
  parameter int unsigned W     = 12,
  parameter int unsigned NW    = 4,
  parameter int unsigned IDX   = 0,
  parameter bit          TRACE = 1'b0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [NW-1:0] n_i,
  input  logic [W-1:0]  mask_i,
  input  logic [W-1:0]  modlow_i,
  input  logic          valid_i,
  input  logic          zero_i,
  input  logic [W-1:0]  con_i,
  input  logic [W-1:0]  x_i,
  input  logic [W-1:0]  acc_i,
  output logic          valid_o,
  output logic          zero_o,
  output logic [W-1:0]  con_o,
  output logic [W-1:0]  x_o,
  output logic [W-1:0]  acc_o
);

  logic [W-1:0] sq, prod, acc_d, acc_q, x_q, con_q;
  logic         act, valid_q, zero_q;

  qrc_mul #(.W(W)) u_sq (.a_i(x_i), .b_i(x_i), .mask_i(mask_i), .modlow_i(modlow_i),
                         .p_o(sq));
  qrc_mul #(.W(W)) u_pr (.a_i(acc_i), .b_i(x_i), .mask_i(mask_i), .modlow_i(modlow_i),
                         .p_o(prod));

  // The inversion chain starts folding at the second power of two.
  assign act = (TRACE || (IDX != 0)) && (NW'(IDX) < n_i);

  always_comb begin
    acc_d = acc_i;
    if (act) begin
      acc_d = TRACE ? (acc_i ^ x_i) : prod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= zero_i;
    con_q  <= con_i;
    x_q    <= sq;
    acc_q  <= acc_d;
  end

  assign valid_o = valid_q;
  assign zero_o  = zero_q;
  assign con_o   = con_q;
  assign x_o     = x_q;
  assign acc_o   = acc_q;

endmodule
